/* hw/rtl/ilp_pkg.sv */
`timescale 1ns / 1ps

package ilp_pkg;

   localparam int CharWidth  = 8;
   localparam int OctetWidth = 8;
   localparam int AccWidth   = 10;
   localparam logic [AccWidth-1:0] OctetMax = AccWidth'(255);

   localparam logic [CharWidth-1:0] CharTab = 8'd9;
   localparam logic [CharWidth-1:0] CharDot = 8'd46;

   typedef enum logic [3:0] {
      PH_LEAD = 4'd0,
      PH_OCT0 = 4'd1,
      PH_OCT1 = 4'd2,
      PH_OCT2 = 4'd3,
      PH_OCT3 = 4'd4,
      PH_GAP  = 4'd5,
      PH_WORD = 4'd6
   } phase_type;

   typedef struct packed {
      logic       is_space;
      logic       is_tab;
      logic       is_digit;
      logic       is_word;
      logic       is_dot;
      logic [3:0] digit;
   } char_class_type;

endpackage

/* hw/rtl/ipv4_line_parser.sv */
`timescale 1ns / 1ps
// the result appears on rsp in the cycle after the request carrying tlast is accepted
// throughput: one character per cycle unless stalled, results held in an output register
// req_tready drops only while a result waits and rsp_tready is low
// synchronous active-high reset returns the parser to leading whitespace
// and empties the result register

module ipv4_line_parser
   import ilp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code[7:0]
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // octet_fourth, octet_third, octet_second, octet_first
   output logic        rsp_tuser    // line_valid
);

   char_class_type cls;

   phase_type             phase_ff, phase_in;
   logic [1:0]            digit_count_ff, digit_count_in;
   logic [AccWidth-1:0]   acc_ff, acc_in;
   logic [OctetWidth-1:0] octet_ff [4];
   logic [OctetWidth-1:0] octet_in [4];
   logic [1:0]            gap_tabs_ff, gap_tabs_in;
   logic                  gap2_tab_ff, gap2_tab_in;
   logic [1:0]            runs_ff, runs_in;
   logic                  err_ff, err_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [1:0]            oct_idx;
   logic                  gap_tab;
   logic                  tail_ok;
   logic                  line_ok;
   logic [AccWidth-1:0]   acc_times_ten;

   ilp_char_class u_class (
      .char_code  (req_tdata),
      .char_class (cls)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign oct_idx    = 2'(phase_ff - PH_OCT0);
   assign acc_times_ten = AccWidth'({acc_ff, 3'b000}) + AccWidth'({acc_ff, 1'b0});

   // per-character parse step
   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      acc_in         = acc_ff;
      octet_in       = octet_ff;
      gap_tabs_in    = gap_tabs_ff;
      gap2_tab_in    = gap2_tab_ff;
      runs_in        = runs_ff;
      err_in         = err_ff;
      gap_tab        = 1'b0;

      if (!err_ff) begin
         case (phase_ff)
            PH_LEAD: begin
               if (cls.is_digit) begin
                  phase_in       = PH_OCT0;
                  acc_in         = AccWidth'(cls.digit);
                  digit_count_in = 2'd1;
               end else if (!cls.is_space) begin
                  err_in = 1'b1;
               end
            end
            PH_OCT0, PH_OCT1, PH_OCT2, PH_OCT3: begin
               if (cls.is_digit) begin
                  if (digit_count_ff == 2'd3) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in         = acc_times_ten + AccWidth'(cls.digit);
                     digit_count_in = digit_count_ff + 2'd1;
                  end
               end else if (cls.is_dot && (phase_ff != PH_OCT3) && (digit_count_ff != 2'd0)) begin
                  if (acc_ff > OctetMax) err_in = 1'b1;
                  octet_in[oct_idx] = acc_ff[OctetWidth-1:0];
                  acc_in            = '0;
                  digit_count_in    = 2'd0;
                  phase_in          = phase_type'(phase_ff + 4'd1);
               end else if (cls.is_space && (phase_ff == PH_OCT3) && (digit_count_ff != 2'd0)) begin
                  if (acc_ff > OctetMax) err_in = 1'b1;
                  octet_in[oct_idx] = acc_ff[OctetWidth-1:0];
                  acc_in            = '0;
                  digit_count_in    = 2'd0;
                  phase_in          = PH_GAP;
                  gap_tab           = cls.is_tab;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_GAP, PH_WORD: begin
               if (cls.is_space) begin
                  phase_in = PH_GAP;
                  gap_tab  = cls.is_tab;
               end else if (cls.is_word) begin
                  if ((phase_ff == PH_GAP) && (runs_ff != 2'd3)) runs_in = runs_ff + 2'd1;
                  phase_in = PH_WORD;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase

         // tab bookkeeping per gap
         if (gap_tab) begin
            if (runs_ff == 2'd0) begin
               if (gap_tabs_ff != 2'd2) gap_tabs_in = gap_tabs_ff + 2'd1;
            end else if (runs_ff == 2'd1) begin
               gap2_tab_in = 1'b1;
            end
         end
      end

      case (runs_in)
         2'd0:    tail_ok = (gap_tabs_in == 2'd2);
         2'd1:    tail_ok = (gap_tabs_in == 2'd2) || ((gap_tabs_in != 2'd0) && gap2_tab_in);
         2'd2:    tail_ok = (gap_tabs_in != 2'd0) && gap2_tab_in;
         default: tail_ok = 1'b0;
      endcase
      line_ok = !err_in && tail_ok && ((phase_in == PH_GAP) || (phase_in == PH_WORD));

      rsp_ok_in   = line_ok;
      rsp_data_in = line_ok ? {octet_in[3], octet_in[2], octet_in[1], octet_in[0]} : '0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept && req_tlast) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         phase_ff       <= PH_LEAD;
         digit_count_ff <= 2'd0;
         acc_ff         <= '0;
         octet_ff       <= '{default: '0};
         gap_tabs_ff    <= 2'd0;
         gap2_tab_ff    <= 1'b0;
         runs_ff        <= 2'd0;
         err_ff         <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         acc_ff         <= acc_in;
         octet_ff       <= octet_in;
         gap_tabs_ff    <= gap_tabs_in;
         gap2_tab_ff    <= gap2_tab_in;
         runs_ff        <= runs_in;
         err_ff         <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> rsp_tvalid)
      else $error("accepted line end did not produce a result");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (phase_ff == PH_LEAD) && !err_ff && (runs_ff == 2'd0))
      else $error("parser state not cleared after line end");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 32'd0))
      else $error("invalid line reported non-zero octets");

   a_acc_empty: assert property (@(posedge clock) disable iff (reset)
      (digit_count_ff == 2'd0) |-> (acc_ff == '0))
      else $error("accumulator holds value with no digits");

endmodule

/* hw/rtl/ilp_char_class.sv */
`timescale 1ns / 1ps

module ilp_char_class
   import ilp_pkg::*;
(
   input  logic [CharWidth-1:0] char_code,
   output char_class_type       char_class
);

   logic digit_c;
   logic upper_c;
   logic lower_c;

   assign digit_c = (char_code >= 8'd48) && (char_code <= 8'd57);
   assign upper_c = (char_code >= 8'd65) && (char_code <= 8'd90);
   assign lower_c = (char_code >= 8'd97) && (char_code <= 8'd122);

   always_comb begin
      char_class.is_space = (char_code == 8'd32) || ((char_code >= 8'd9) && (char_code <= 8'd13));
      char_class.is_tab   = (char_code == CharTab);
      char_class.is_digit = digit_c;
      char_class.is_word  = digit_c || upper_c || lower_c || (char_code == 8'd95);
      char_class.is_dot   = (char_code == CharDot);
      char_class.digit    = 4'(char_code - 8'd48);
   end

endmodule

/* tb/sv/ipv4_line_parser_tb.sv */
`timescale 1ns / 1ps

module ipv4_line_parser_tb
   import ilp_pkg::*;
();

   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChLf    = 8'h0a;
   localparam logic [7:0] ChVt    = 8'h0b;
   localparam logic [7:0] ChFf    = 8'h0c;
   localparam logic [7:0] ChCr    = 8'h0d;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChUpA   = 8'h41;
   localparam logic [7:0] ChUpZ   = 8'h5a;
   localparam logic [7:0] ChLowA  = 8'h61;
   localparam logic [7:0] ChLowZ  = 8'h7a;
   localparam logic [7:0] ChUnder = 8'h5f;

   localparam int CharTarget  = 1650;
   localparam int SettleTicks = 8;

   typedef struct packed {
      logic        valid;
      logic [31:0] octets;
   } line_result_type;

   class ipv4_line_checker;
      phase_type       ph;
      logic [1:0]      digits;
      logic [9:0]      acc;
      logic [7:0]      octets [4];
      logic [1:0]      first_gap_tabs;
      logic            second_gap_tab;
      logic [1:0]      runs;
      logic            failed;
      line_result_type expected_lines [$];
      int              errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         ph = PH_LEAD;
         digits = '0;
         acc = '0;
         foreach (octets[i]) octets[i] = '0;
         first_gap_tabs = '0;
         second_gap_tab = 1'b0;
         runs = '0;
         failed = 1'b0;
      endfunction

      function logic is_ws(logic [7:0] c);
         return c == ChSpace || (c >= CharTab && c <= ChCr);
      endfunction

      function logic is_num(logic [7:0] c);
         return c >= ChZero && c <= ChNine;
      endfunction

      function logic is_word(logic [7:0] c);
         return is_num(c) || (c >= ChUpA && c <= ChUpZ) || (c >= ChLowA && c <= ChLowZ)
            || c == ChUnder;
      endfunction

      function void close_octet(int k);
         if (acc > OctetMax) failed = 1'b1;
         octets[k] = acc[7:0];
         acc = '0;
         digits = '0;
      endfunction

      function void gap_char(logic [7:0] c);
         if (c != CharTab) return;
         if (runs == 2'd0) begin
            if (first_gap_tabs < 2'd2) first_gap_tabs++;
         end else if (runs == 2'd1) begin
            second_gap_tab = 1'b1;
         end
      endfunction

      function void step(logic [7:0] c);
         int k;
         k = int'(ph) - int'(PH_OCT0);
         case (ph)
            PH_LEAD: begin
               if (is_num(c)) begin
                  ph = PH_OCT0;
                  acc = 10'(c - ChZero);
                  digits = 2'd1;
               end else if (!is_ws(c)) begin
                  failed = 1'b1;
               end
            end
            PH_OCT0, PH_OCT1, PH_OCT2, PH_OCT3: begin
               if (is_num(c)) begin
                  if (digits == 2'd3) begin
                     failed = 1'b1;
                  end else begin
                     acc = 10'(acc * 10 + 10'(c - ChZero));
                     digits++;
                  end
               end else if (c == CharDot && k < 3 && digits != 2'd0) begin
                  close_octet(k);
                  ph = phase_type'(ph + 1);
               end else if (is_ws(c) && k == 3 && digits != 2'd0) begin
                  close_octet(k);
                  ph = PH_GAP;
                  gap_char(c);
               end else begin
                  failed = 1'b1;
               end
            end
            PH_GAP, PH_WORD: begin
               if (is_ws(c)) begin
                  ph = PH_GAP;
                  gap_char(c);
               end else if (is_word(c)) begin
                  if (ph == PH_GAP && runs < 2'd3) runs++;
                  ph = PH_WORD;
               end else begin
                  failed = 1'b1;
               end
            end
            default: failed = 1'b1;
         endcase
      endfunction

      function logic tail_fits();
         if (ph != PH_GAP && ph != PH_WORD) return 1'b0;
         case (runs)
            2'd0: return first_gap_tabs >= 2'd2;
            2'd1: return first_gap_tabs >= 2'd2 || (first_gap_tabs >= 2'd1 && second_gap_tab);
            2'd2: return first_gap_tabs >= 2'd1 && second_gap_tab;
            default: return 1'b0;
         endcase
      endfunction

      function void note_char(logic [7:0] c, logic last);
         line_result_type r;
         logic ok;
         if (!failed) step(c);
         if (last) begin
            ok = !failed && tail_fits();
            r.valid = ok;
            r.octets = ok ? {octets[3], octets[2], octets[1], octets[0]} : '0;
            expected_lines.push_back(r);
            clear();
         end
      endfunction

      function void check_result(logic valid, logic [31:0] data);
         line_result_type e;
         int i;
         if (expected_lines.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual valid %0b octets %h",
                     $time, valid, data);
            errors++;
            return;
         end
         e = expected_lines.pop_front();
         if (valid !== e.valid) begin
            $display("%0t: line_valid expected %0b actual %0b", $time, e.valid, valid);
            errors++;
         end
         for (i = 0; i < 4; i++) begin
            if (data[8*i +: 8] !== e.octets[8*i +: 8]) begin
               $display("%0t: octet %0d expected %0d actual %0d", $time, i,
                        e.octets[8*i +: 8], data[8*i +: 8]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   ipv4_line_checker addr_check = new();

   logic [7:0] line_buf [$];
   int         burst_left = 0;
   int         sent_chars = 0;
   int         ready_mode = 0;
   int         ready_hold = 0;

   ipv4_line_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) addr_check.note_char(req_tdata, req_tlast);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) addr_check.check_result(rsp_tuser, rsp_tdata);
   end

   // receiver: free-running, coin-flip and long-stall stretches
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_hold = $urandom_range(40, 300);
      end
      ready_hold--;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   function void put(logic [7:0] c);
      line_buf.push_back(c);
   endfunction

   function void put_str(string s);
      int i;
      for (i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function logic [7:0] any_ws();
      int k;
      k = $urandom_range(8, 13);
      return k == 8 ? ChSpace : 8'(k);
   endfunction

   function logic [7:0] plain_ws();
      int k;
      k = $urandom_range(9, 13);
      return k == 9 ? ChSpace : 8'(k);
   endfunction

   function logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0: return 8'(ChZero + $urandom_range(0, 9));
         1: return 8'(ChUpA + $urandom_range(0, 25));
         2: return 8'(ChLowA + $urandom_range(0, 25));
         default: return ChUnder;
      endcase
   endfunction

   function void put_gap(int tabs);
      int extra, n, left, i;
      extra = $urandom_range(tabs == 0 ? 1 : 0, 2);
      n = tabs + extra;
      left = tabs;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(1, n - i) <= left) begin
            put(CharTab);
            left--;
         end else begin
            put(plain_ws());
         end
      end
   endfunction

   function void put_group();
      int v, n, i;
      case ($urandom_range(0, 19))
         0: for (i = 0; i < 4; i++) put(8'(ChZero + $urandom_range(0, 9)));
         1: ;
         2, 3: for (i = 0; i < 3; i++) put(8'(ChZero + $urandom_range(0, 9)));
         default: begin
            case ($urandom_range(0, 5))
               0: v = 255;
               1: v = 0;
               default: v = $urandom_range(0, 255);
            endcase
            n = v >= 100 ? 3 : (v >= 10 ? 2 : 1);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(n, 3);
            for (i = n - 1; i >= 0; i--) put(8'(ChZero + (v / 10**i) % 10));
         end
      endcase
   endfunction

   function void put_address_line();
      int lead, runs, g, i, n;
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (i = 0; i < lead; i++) put(any_ws());
      for (g = 0; g < 4; g++) begin
         put_group();
         if (g < 3) put(CharDot);
      end
      if ($urandom_range(0, 11) == 0) return;
      case ($urandom_range(0, 9))
         0, 1: runs = 0;
         2, 3, 4: runs = 1;
         9: runs = 3;
         default: runs = 2;
      endcase
      put_gap($urandom_range(0, 3));
      for (i = 0; i < runs; i++) begin
         n = $urandom_range(1, 4);
         repeat (n) put(word_char());
         if (i < runs - 1 || $urandom_range(0, 1) == 1)
            put_gap(i == 0 ? $urandom_range(0, 2) : $urandom_range(0, 1));
      end
   endfunction

   function void mutate_line();
      int at;
      at = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
         0: line_buf[at] = 8'($urandom_range(0, 255));
         1: line_buf.insert(at, CharDot);
         default: begin
            if (line_buf.size() > 1) line_buf.delete(at);
            else line_buf[at] = word_char();
         end
      endcase
   endfunction

   function void make_line();
      int n, i;
      case ($urandom_range(0, 9))
         7: begin
            put_address_line();
            mutate_line();
         end
         8: begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
         end
         9: begin
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0: put(8'(ChZero + $urandom_range(0, 9)));
                  1: put(CharDot);
                  2: put(any_ws());
                  default: put(word_char());
               endcase
            end
         end
         default: put_address_line();
      endcase
   endfunction

   task automatic send_char(logic [7:0] c, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_line();
      int i, n;
      n = line_buf.size();
      for (i = 0; i < n; i++) send_char(line_buf[i], i == n - 1);
      sent_chars += n;
      line_buf.delete();
   endtask

   task automatic send_text(string s);
      put_str(s);
      send_line();
   endtask

   // hold off requests until every line result has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (addr_check.pending() != 0);
      burst_left = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("0.0.0.0\t\t");
      send_text("255.255.255.255\t\tx");
      send_text(" \t192.168.1.1\tab\tcd");
      send_text("1.2.3.4\tw \t");
      send_text("1.2.3.4\tw");
      send_text("256.1.1.1\t\t");
      send_text("9.9.9.999\t\t");
      send_text("1234.1.1.1\t\t");
      send_text("1..1.1\t\t");
      send_text("1.2.3.4");
      send_text("1.2.3.4\ta\tb\tc");
      send_text("1.2.3.4\t\ta b");
      send_text("x");
      send_text("\t");
      send_text("7");
      send_text("1.2.3.4.5\t\t");
      send_text("01.002.030.4\t\t");
      send_text("1.2.3.4\t\t-");
      send_text("1.2.3.4\ta\t\tb  ");
      send_text("1.2.3.4\t\t\t\ta");
      put(ChLf); put(ChVt); put(ChFf); put(ChCr); put(ChSpace);
      put_str("10.20.30.40"); put(ChCr); put(CharTab); put(ChLf); put(CharTab);
      put_str("_Z9");
      send_line();
      put_str("1.2.3."); put(8'hff); put_str("\t\t");
      send_line();
      put_str("1.2.3.4\t"); put(8'h80); put(8'h00);
      send_line();
      drain();

      while (sent_chars < CharTarget) begin
         make_line();
         send_line();
         if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
      repeat (SettleTicks) @(posedge clock);

      if (addr_check.errors == 0 && addr_check.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/ilp_pkg.sv
hw/rtl/ilp_char_class.sv
hw/rtl/ipv4_line_parser.sv
tb/sv/ipv4_line_parser_tb.sv
